### src/scbc_pkg.sv
// Shared types, codes and constants for the size class buffer cache.
// Used by the controller, datapath and top level; depends on nothing.
package scbc_pkg;

    localparam int HANDLE_BITS_DEF     = 16;
    localparam int PER_CLASS_DEPTH_DEF = 20;
    localparam int LARGE_CLASSES_DEF   = 8;

    localparam int FIXED_CLASSES = 8;
    localparam int LARGE_SHIFT   = 26;

    localparam logic [32:0] FIXED_CLASS_BYTES [FIXED_CLASSES] = '{
        33'd1024, 33'd4096, 33'd16384, 33'd65536,
        33'd262144, 33'd1048576, 33'd4194304, 33'd16777216
    };

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_CACHED  = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;
    localparam logic [2:0] ST_CLEARED = 3'd6;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] byte_count;
        logic [15:0] handle_in;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] handle_out;
        logic [32:0] class_size;
        logic [39:0] total_cached_bytes;
        logic [8:0]  total_cached_handles;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLASSIFY,
        S_DECIDE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic classify;
        logic decide;
    } t_cmd;

endpackage

### src/scbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; used for the class table and the handle store.
module scbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/scbc_ctrl.sv
// Request sequencer: accept, classify, decide, respond.
// Depends on scbc_pkg for the state and command types.
module scbc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    output logic           o_done,
    output scbc_pkg::t_cmd o_cmd
);
    import scbc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: n_state = S_DECIDE;
            S_DECIDE:   n_state = S_RESP;
            S_RESP:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_CLASSIFY: o_cmd.classify = 1'b1;
            S_DECIDE:   o_cmd.decide   = 1'b1;
            S_RESP:     o_done         = 1'b1;
            default:    busy           = 1'b1;
        endcase
    end

endmodule

### src/scbc_datapath.sv
// Datapath: size class rounding, per-class FIFO bookkeeping, byte and handle totals.
// Depends on scbc_pkg and scbc_ram (class table and handle store).
module scbc_datapath #(
    parameter int HANDLE_BITS     = scbc_pkg::HANDLE_BITS_DEF,
    parameter int PER_CLASS_DEPTH = scbc_pkg::PER_CLASS_DEPTH_DEF,
    parameter int LARGE_CLASSES   = scbc_pkg::LARGE_CLASSES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scbc_pkg::t_cmd i_cmd,
    input  scbc_pkg::t_req i_req,
    input  logic           i_cfg_we,
    input  logic [39:0]    i_cfg_wdata,
    output scbc_pkg::t_res o_res
);
    import scbc_pkg::*;

    localparam int NUM_CLASSES = FIXED_CLASSES + LARGE_CLASSES;
    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int HW          = HANDLE_BITS < 16 ? HANDLE_BITS : 16;
    localparam int PTR_W       = PER_CLASS_DEPTH > 1 ? $clog2(PER_CLASS_DEPTH) : 1;
    localparam int CNT_W       = $clog2(PER_CLASS_DEPTH + 1);
    localparam int META_W      = PTR_W + CNT_W;
    localparam int STORE_DEPTH = NUM_CLASSES * PER_CLASS_DEPTH;
    localparam int SA_W        = $clog2(STORE_DEPTH);
    localparam int HT_W        = $clog2(STORE_DEPTH + 1);

    localparam logic [SA_W-1:0]  DEPTH_SA  = SA_W'(PER_CLASS_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PER_CLASS_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(PER_CLASS_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_PTR = (PTR_W + 1)'(PER_CLASS_DEPTH);
    localparam logic [7:0]       LARGE_LIM = 8'(LARGE_CLASSES);

    // Request and classification registers
    t_req              r_req;
    logic              r_zero;
    logic              r_cacheable;
    logic [CLS_W-1:0]  r_cls;
    logic [SA_W-1:0]   r_base;
    logic [32:0]       r_csize;

    // Control state
    logic [39:0]           r_max_bytes;
    logic [39:0]           r_bytes;
    logic [HT_W-1:0]       r_handles;
    logic [NUM_CLASSES-1:0] r_valid;

    // Result registers
    logic [2:0]  r_status;
    logic [32:0] r_class_size;

    // Classification logic
    logic [2:0]       fixed_idx;
    logic             fixed_hit;
    logic [6:0]       large_k;
    logic [7:0]       large_cls;
    logic [CLS_W-1:0] cls_c;
    logic             cacheable_c;
    logic [32:0]      csize_c;

    always_comb begin
        fixed_idx = '0;
        fixed_hit = 1'b0;
        for (int i = FIXED_CLASSES - 1; i >= 0; i--) begin
            if ({1'b0, r_req.byte_count} <= FIXED_CLASS_BYTES[i]) begin
                fixed_hit = 1'b1;
                fixed_idx = 3'(i);
            end
        end
        // Ceiling of size over the 64 MiB step.
        large_k   = {1'b0, r_req.byte_count[31:LARGE_SHIFT]} + 7'(|r_req.byte_count[25:0]);
        large_cls = 8'(FIXED_CLASSES) + {1'b0, large_k} - 8'd1;
        if (fixed_hit) begin
            cls_c       = CLS_W'(fixed_idx);
            cacheable_c = 1'b1;
            csize_c     = FIXED_CLASS_BYTES[fixed_idx];
        end else begin
            cls_c       = CLS_W'(large_cls);
            cacheable_c = ({1'b0, large_k} <= LARGE_LIM);
            csize_c     = {large_k, 26'd0};
        end
    end

    // Class table: head and count per class; an entry not marked valid reads as empty.
    logic [META_W-1:0] meta_rdata;
    logic              meta_we;
    logic [META_W-1:0] meta_wdata;
    logic [PTR_W-1:0]  head;
    logic [CNT_W-1:0]  count;

    scbc_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_CLASSES)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_cls),
        .i_wdata (meta_wdata),
        .i_re    (i_cmd.classify),
        .i_raddr (cls_c),
        .o_rdata (meta_rdata)
    );

    logic [HW-1:0]   store_rdata;
    logic            store_we;
    logic            store_re;
    logic [SA_W-1:0] store_waddr;
    logic [SA_W-1:0] store_raddr;

    scbc_ram #(
        .WIDTH (HW),
        .DEPTH (STORE_DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (r_req.handle_in[HW-1:0]),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    // Decision logic
    logic [PTR_W:0]   head_inc;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W:0]   pos_sum;
    logic [PTR_W-1:0] push_pos;
    logic [40:0]      bytes_after_push;
    logic             can_push;
    logic             hit;
    logic             push;
    logic             clear_all;
    logic [2:0]       n_status;
    logic [32:0]      n_class_size;
    logic [39:0]      n_bytes;
    logic [HT_W-1:0]  n_handles;

    always_comb begin
        if (r_valid[r_cls] && r_cacheable) begin
            head  = meta_rdata[META_W-1:CNT_W];
            count = meta_rdata[CNT_W-1:0];
        end else begin
            head  = '0;
            count = '0;
        end

        head_inc  = {1'b0, head} + (PTR_W + 1)'(1);
        head_next = (head_inc == DEPTH_PTR) ? '0 : head_inc[PTR_W-1:0];
        pos_sum   = (CNT_W + 1)'(head) + {1'b0, count};
        if (pos_sum >= DEPTH_SUM) begin
            pos_sum = pos_sum - DEPTH_SUM;
        end
        push_pos = pos_sum[PTR_W-1:0];

        bytes_after_push = {1'b0, r_bytes} + 41'(r_csize);
        can_push = r_cacheable && (count < DEPTH_CNT)
                   && (bytes_after_push <= {1'b0, r_max_bytes});

        hit          = 1'b0;
        push         = 1'b0;
        clear_all    = 1'b0;
        n_status     = ST_IGNORED;
        n_class_size = '0;
        n_bytes      = r_bytes;
        n_handles    = r_handles;
        meta_wdata   = {head, count};

        case (r_req.operation)
            OP_ACQUIRE: begin
                if (r_zero) begin
                    n_status = ST_ZERO;
                end else begin
                    n_class_size = r_csize;
                    if (r_cacheable && count != '0) begin
                        hit        = 1'b1;
                        n_status   = ST_HIT;
                        n_bytes    = r_bytes - 40'(r_csize);
                        n_handles  = r_handles - HT_W'(1);
                        meta_wdata = {head_next, count - CNT_W'(1)};
                    end else begin
                        n_status = ST_MISS;
                    end
                end
            end
            OP_RELEASE: begin
                if (r_req.handle_in[HW-1:0] != '0 && !r_zero) begin
                    n_class_size = r_csize;
                    if (can_push) begin
                        push       = 1'b1;
                        n_status   = ST_CACHED;
                        n_bytes    = bytes_after_push[39:0];
                        n_handles  = r_handles + HT_W'(1);
                        meta_wdata = {head, count + CNT_W'(1)};
                    end else begin
                        n_status = ST_DROPPED;
                    end
                end
            end
            OP_CLEAR: begin
                clear_all = 1'b1;
                n_status  = ST_CLEARED;
                n_bytes   = '0;
                n_handles = '0;
            end
            default: n_status = ST_IGNORED;
        endcase
    end

    assign meta_we     = i_cmd.decide && (hit || push);
    assign store_we    = i_cmd.decide && push;
    assign store_re    = i_cmd.decide && hit;
    assign store_waddr = r_base + SA_W'(push_pos);
    assign store_raddr = r_base + SA_W'(head);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.classify) begin
            r_zero      <= (r_req.byte_count == 32'd0);
            r_cacheable <= cacheable_c;
            r_cls       <= cls_c;
            r_base      <= SA_W'(cls_c) * DEPTH_SA;
            r_csize     <= csize_c;
        end
        if (i_cmd.decide) begin
            r_status     <= n_status;
            r_class_size <= n_class_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= '0;
            r_bytes     <= '0;
            r_handles   <= '0;
            r_valid     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_bytes <= i_cfg_wdata;
            end
            if (i_cmd.decide) begin
                r_bytes   <= n_bytes;
                r_handles <= n_handles;
                if (clear_all) begin
                    r_valid <= '0;
                end else if (hit || push) begin
                    r_valid[r_cls] <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_res.status               = r_status;
        o_res.handle_out           = (r_status == ST_HIT) ? 16'(store_rdata) : 16'd0;
        o_res.class_size           = r_class_size;
        o_res.total_cached_bytes   = r_bytes;
        o_res.total_cached_handles = 9'(r_handles);
    end

endmodule

### src/size_class_buffer_cache_unit.sv
// Top level of the size class buffer cache: controller, datapath and assertions.
// Depends on scbc_pkg, scbc_ctrl, scbc_datapath and scbc_ram.
//
// Usage. A request (operation, byte_count, handle_in) is taken at a rising edge
// where start is high and busy is low. Operations are acquire, release and
// clear; acquire returns the oldest cached handle of the size class or a miss
// with the class size, release caches a handle if its class has room and the
// byte ceiling allows it, clear empties every class.
// The result appears on o_res with o_done high for exactly one cycle; o_res then
// holds it until the next request's decision. busy stays high from acceptance
// through the result cycle, so a new request is not taken until the last one has
// finished. The steps are the class table read, the decision with its table and
// store writes, and the registered handle store read.
// The receiver cannot stall: o_done is a one-cycle strobe. max_cached_bytes is
// written through i_cfg_we / i_cfg_wdata; the user must do so only while the
// block is idle, which the block itself does not enforce. Reset clears the class
// valid bits, the totals and the ceiling at once; the handle store needs no
// clearing, so the block is ready as soon as reset is released.
module size_class_buffer_cache_unit #(
    parameter int HANDLE_BITS     = scbc_pkg::HANDLE_BITS_DEF,
    parameter int PER_CLASS_DEPTH = scbc_pkg::PER_CLASS_DEPTH_DEF,
    parameter int LARGE_CLASSES   = scbc_pkg::LARGE_CLASSES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  scbc_pkg::t_req i_req,
    output logic           o_done,
    output scbc_pkg::t_res o_res,
    input  logic           i_cfg_we,
    input  logic [39:0]    i_cfg_wdata
);
    import scbc_pkg::*;

    t_cmd cmd;

    scbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    scbc_datapath #(
        .HANDLE_BITS     (HANDLE_BITS),
        .PER_CLASS_DEPTH (PER_CLASS_DEPTH),
        .LARGE_CLASSES   (LARGE_CLASSES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (o_res)
    );

`ifndef ASSERT_OFF
    // Every accepted request produces its result strobe once the classify and decide states have passed.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("result strobe missing after accepted request");

    // The result cycle belongs to a request still in progress.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // Only a hit returns a handle.
    a_handle_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != ST_HIT) |-> (o_res.handle_out == 16'd0))
        else $error("handle returned on a result that is not a hit");

    // A clear leaves nothing cached.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_CLEARED)
            |-> (o_res.total_cached_bytes == 40'd0 && o_res.total_cached_handles == 9'd0))
        else $error("totals not zero after clear");
`endif

endmodule
